// ===== hw/rtl/jbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, character codes and byte classifiers for the JSON byte
// tokenizer and its checker.
// ----------------------------------------------------------------------------
package jbt_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int SPAN_BITS       = 32;
    localparam int MAX_TOKENS      = 3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_STR   = 2'd1,
        MODE_BARE  = 2'd2,
        MODE_AFTER = 2'd3
    } t_scan_mode;

    typedef enum logic [2:0] {
        TK_OBRACE = 3'd0,
        TK_CBRACE = 3'd1,
        TK_OBRACK = 3'd2,
        TK_CBRACK = 3'd3,
        TK_COMMA  = 3'd4,
        TK_KEY    = 3'd5,
        TK_PRIM   = 3'd6,
        TK_END    = 3'd7
    } t_tok_kind;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_struct(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
               (b == CH_RBRACK) || (b == CH_COMMA);
    endfunction

    // Bytes that end a bare run; the byte itself is then handled as in idle.
    function automatic logic is_delim(input logic [7:0] b);
        return (b == CH_RBRACE) || (b == CH_RBRACK) || (b == CH_COMMA) || is_blank(b);
    endfunction

    function automatic t_tok_kind struct_kind(input logic [7:0] b);
        t_tok_kind k;
        unique case (b)
            CH_LBRACE: k = TK_OBRACE;
            CH_RBRACE: k = TK_CBRACE;
            CH_LBRACK: k = TK_OBRACK;
            CH_RBRACK: k = TK_CBRACK;
            default:   k = TK_COMMA;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/json_byte_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON tokenizer: one byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// A byte is taken into an input register; from there the scan state is
// updated and its tokens (at most three) are loaded into a small token group
// register, from which one token leaves per cycle while the consumer is ready.
// A byte that yields k tokens occupies the token group register until all k
// have left, so the rate is one byte per cycle on token-sparse text when the
// consumer does not stall, and lower where bytes yield several tokens, set by
// the single output port of the token group register.
// The input register lets the next byte be taken while the last token of a
// group still waits for the consumer. No start-up sweep is needed after reset.
// ----------------------------------------------------------------------------
module json_byte_tokenizer #(
    parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_byte_in,
    input  wire logic                         i_stream_end,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [2:0]                        o_token_kind,
    output logic [jbt_pkg::SPAN_BITS-1:0]     o_span_start,
    output logic [jbt_pkg::SPAN_BITS-1:0]     o_span_end,
    output logic                              o_last_of_run
);
    import jbt_pkg::*;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [SPAN_BITS-1:0]   t_span;

    localparam t_off POS_MAX = '1;

    function automatic t_off sat_inc(input t_off v);
        return (v == POS_MAX) ? v : v + t_off'(1);
    endfunction

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    // Scan state.
    t_scan_mode r_mode;
    logic       r_odd;
    t_off       r_begin;
    t_off       r_qpos;
    t_off       r_pos;

    // Token group register; entry 0 is on the output.
    t_tok_kind  r_kind  [MAX_TOKENS];
    t_span      r_start [MAX_TOKENS];
    t_span      r_end   [MAX_TOKENS];
    logic [1:0] r_cnt;

    // State after the byte, before any end-of-stream reset.
    t_scan_mode w_mid_mode;
    logic       w_mid_odd;
    t_off       w_mid_begin;
    t_off       w_mid_qpos;
    logic       w_idle_byte;

    t_tok_kind  n_kind  [MAX_TOKENS];
    t_span      n_start [MAX_TOKENS];
    t_span      n_end   [MAX_TOKENS];
    logic [1:0] n_cnt;

    logic       w_grp_free;
    logic       w_advance;
    logic       w_out_fire;
    t_off       w_pos_inc;

    assign o_out_valid   = (r_cnt != 2'd0);
    assign w_out_fire    = o_out_valid && i_out_ready;
    assign w_grp_free    = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign w_advance     = r_in_valid && w_grp_free;
    assign o_in_ready    = !r_in_valid || w_grp_free;
    assign w_pos_inc     = sat_inc(r_pos);

    assign o_token_kind  = r_kind[0];
    assign o_span_start  = r_start[0];
    assign o_span_end    = r_end[0];
    assign o_last_of_run = (r_cnt == 2'd1);

    // Next scan state.
    always_comb begin
        w_mid_mode  = r_mode;
        w_mid_odd   = r_odd;
        w_mid_begin = r_begin;
        w_mid_qpos  = r_qpos;
        w_idle_byte = 1'b0;
        unique case (r_mode)
            MODE_STR: begin
                if (r_in_byte == CH_BSLASH) begin
                    w_mid_odd = ~r_odd;
                end else if (r_in_byte == CH_QUOTE && !r_odd) begin
                    w_mid_qpos = r_pos;
                    w_mid_mode = MODE_AFTER;
                end else begin
                    w_mid_odd = 1'b0;
                end
            end
            MODE_BARE: begin
                if (is_delim(r_in_byte)) begin
                    w_mid_mode  = MODE_IDLE;
                    w_idle_byte = 1'b1;
                end
            end
            MODE_AFTER: begin
                if (!is_blank(r_in_byte)) begin
                    w_mid_mode  = MODE_IDLE;
                    w_idle_byte = (r_in_byte != CH_COLON);
                end
            end
            default: begin
                w_idle_byte = 1'b1;
            end
        endcase
        if (w_idle_byte) begin
            if (r_in_byte == CH_QUOTE) begin
                w_mid_mode  = MODE_STR;
                w_mid_odd   = 1'b0;
                w_mid_begin = r_pos;
            end else if (is_alnum(r_in_byte)) begin
                w_mid_mode  = MODE_BARE;
                w_mid_begin = r_pos;
            end
        end
    end

    // Tokens of the byte, packed in emission order.
    always_comb begin
        for (int i = 0; i < MAX_TOKENS; i++) begin
            n_kind[i]  = TK_END;
            n_start[i] = '0;
            n_end[i]   = '0;
        end
        n_cnt = 2'd0;
        if (r_mode == MODE_BARE && is_delim(r_in_byte)) begin
            n_kind[n_cnt]  = TK_PRIM;
            n_start[n_cnt] = SPAN_BITS'(r_begin);
            n_end[n_cnt]   = SPAN_BITS'(r_pos);
            n_cnt          = n_cnt + 2'd1;
        end
        if (r_mode == MODE_AFTER && r_in_byte == CH_COLON) begin
            n_kind[n_cnt]  = TK_KEY;
            n_start[n_cnt] = SPAN_BITS'(sat_inc(r_begin));
            n_end[n_cnt]   = SPAN_BITS'(r_qpos);
            n_cnt          = n_cnt + 2'd1;
        end
        if (r_mode == MODE_AFTER && r_in_byte != CH_COLON && !is_blank(r_in_byte)) begin
            n_kind[n_cnt]  = TK_PRIM;
            n_start[n_cnt] = SPAN_BITS'(r_begin);
            n_end[n_cnt]   = SPAN_BITS'(sat_inc(r_qpos));
            n_cnt          = n_cnt + 2'd1;
        end
        if (w_idle_byte && is_struct(r_in_byte)) begin
            n_kind[n_cnt]  = struct_kind(r_in_byte);
            n_start[n_cnt] = SPAN_BITS'(r_pos);
            n_end[n_cnt]   = SPAN_BITS'(w_pos_inc);
            n_cnt          = n_cnt + 2'd1;
        end
        // A string closed but not yet classed when the stream ends is a primitive.
        if (r_in_end && w_mid_mode == MODE_AFTER) begin
            n_kind[n_cnt]  = TK_PRIM;
            n_start[n_cnt] = SPAN_BITS'(w_mid_begin);
            n_end[n_cnt]   = SPAN_BITS'(sat_inc(w_mid_qpos));
            n_cnt          = n_cnt + 2'd1;
        end
        if (r_in_end) begin
            n_kind[n_cnt]  = TK_END;
            n_start[n_cnt] = SPAN_BITS'(w_pos_inc);
            n_end[n_cnt]   = SPAN_BITS'(w_pos_inc);
            n_cnt          = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_in;
            r_in_end  <= i_stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_odd   <= 1'b0;
            r_begin <= '0;
            r_qpos  <= '0;
            r_pos   <= '0;
        end else if (w_advance) begin
            if (r_in_end) begin
                r_mode  <= MODE_IDLE;
                r_odd   <= 1'b0;
                r_begin <= '0;
                r_qpos  <= '0;
                r_pos   <= '0;
            end else begin
                r_mode  <= w_mid_mode;
                r_odd   <= w_mid_odd;
                r_begin <= w_mid_begin;
                r_qpos  <= w_mid_qpos;
                r_pos   <= w_pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_advance) begin
            r_cnt <= n_cnt;
        end else if (w_out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_kind  <= n_kind;
            r_start <= n_start;
            r_end   <= n_end;
        end else if (w_out_fire) begin
            for (int i = 0; i < MAX_TOKENS - 1; i++) begin
                r_kind[i]  <= r_kind[i+1];
                r_start[i] <= r_start[i+1];
                r_end[i]   <= r_end[i+1];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jbt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jbt_checker
// Port-level checks on the JSON byte tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module jbt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [7:0]                    i_byte_in,
    input wire logic                          i_stream_end,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [2:0]                    o_token_kind,
    input wire logic [jbt_pkg::SPAN_BITS-1:0] o_span_start,
    input wire logic [jbt_pkg::SPAN_BITS-1:0] o_span_end,
    input wire logic                          o_last_of_run
);
    import jbt_pkg::*;

    // An accepted byte carries a known payload.
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> !$isunknown({i_byte_in, i_stream_end}))
        else $error("input transaction with unknown payload");

    // A stalled transaction keeps its token.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_token_kind) && $stable(o_span_start) &&
            $stable(o_span_end) && $stable(o_last_of_run))
        else $error("output transaction changed while stalled");

    // The end token always closes the run of its byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == TK_END |-> o_last_of_run)
        else $error("end token not marked last of run");

    // The end token has an empty span.
    a_end_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == TK_END |-> o_span_start == o_span_end)
        else $error("end token span not empty");

    // Reset empties the token group.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token presented straight after reset");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (.*);
`default_nettype wire
